### rtl/bba_pkg.sv
package bba_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned LeafMax     = 4096;
  localparam int unsigned AddrW       = 24;
  localparam int unsigned SizeW       = 24;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned TlCfgW      = 4;
  localparam int unsigned LeafW       = 13;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_TREE_LEVELS = 1'b0,
    CFG_LEAF_BYTES  = 1'b1
  } cfg_idx_e;

endpackage

### rtl/bba_div.sv
module bba_div #(
  parameter int unsigned DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          run_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_q, quo_q[DW-1]};
  assign take  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DW-2:0], take};
      rem_q <= take ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### rtl/buddy_block_allocator.sv
// rejected requests with zero size or an address below the header are answered from idle, strobe in the next cycle
// one request at a time: start_i is taken only in idle, and each request runs through the
// 24-step divider and the list walk through the link memory (one read port, one write port)
// reset and every config write start a clearing pass over all link memory entries with busy high
// one status strobe per request on done_o unless a config write cuts it short; the receiver cannot stall
module buddy_block_allocator #(
  parameter int unsigned NUM_LEVELS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  output logic                          done_o,
  input  logic                          command_i,
  input  logic [bba_pkg::SizeW-1:0]     request_size_i,
  input  logic [bba_pkg::AddrW-1:0]     block_address_i,
  output logic [bba_pkg::StatusW-1:0]   status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bba_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int unsigned NW      = NUM_LEVELS;
  localparam int unsigned SW      = NUM_LEVELS - 1;
  localparam int unsigned LW      = $clog2(NUM_LEVELS);
  localparam int unsigned DW      = (12 + NUM_LEVELS > 24) ? 12 + NUM_LEVELS : 24;
  localparam int unsigned NODES   = 1 << NW;
  localparam int unsigned SLOTS   = 1 << SW;
  localparam int unsigned TlReset = (NUM_LEVELS - 1 < 8) ? NUM_LEVELS - 1 : 8;

  localparam logic [2:0] WmNext = 3'b010;
  localparam logic [2:0] WmPrev = 3'b001;
  localparam logic [2:0] WmAll  = 3'b111;

  typedef struct packed {
    logic          free;
    logic [NW-1:0] nxt;
    logic [NW-1:0] prv;
  } link_t;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_CLEAR   = 18'h00002,
    S_DIV     = 18'h00004,
    S_SCAN    = 18'h00008,
    S_UNL_RD  = 18'h00010,
    S_UNL_P   = 18'h00020,
    S_UNL_X   = 18'h00040,
    S_UNL_N   = 18'h00080,
    S_PB_N    = 18'h00100,
    S_PB_T    = 18'h00200,
    S_OWN_WR  = 18'h00400,
    S_OWN_RD  = 18'h00800,
    S_OWN_CHK = 18'h01000,
    S_FLG_CHK = 18'h02000,
    S_PF_N    = 18'h04000,
    S_PF_H    = 18'h08000,
    S_BUD_RD  = 18'h10000,
    S_BUD_CHK = 18'h20000
  } state_e;

  typedef enum logic [1:0] {
    R_ALLOC   = 2'd0,
    R_MERGE_N = 2'd1,
    R_MERGE_B = 2'd2
  } ret_e;

  state_e  state_q, state_d;
  ret_e    ret_q, ret_d;
  logic    cmd_q, cmd_d;
  logic    child_q, child_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [LW-1:0] want_q, want_d;
  logic [LW-1:0] tl_q, tl_d;
  logic [bba_pkg::LeafW-1:0] leaf_q, leaf_d;
  logic [NW-1:0] node_q, node_d;
  logic [NW-1:0] unode_q, unode_d;
  logic [NW-1:0] lnk_q, lnk_d;
  logic [NW-1:0] xn_q, xn_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [NW-1:0] clr_q, clr_d;
  logic [NW-1:0] head_q [NUM_LEVELS];
  logic [NW-1:0] head_d [NUM_LEVELS];
  logic [NW-1:0] tail_q [NUM_LEVELS];
  logic [NW-1:0] tail_d [NUM_LEVELS];
  logic [NW-1:0] cnt_q  [NUM_LEVELS];
  logic [NW-1:0] cnt_d  [NUM_LEVELS];
  logic    done_q, done_d;
  logic [bba_pkg::StatusW-1:0] status_q, status_d;

  // link memory: free flag and list links per node, field write enables
  link_t   link_mem [NODES];
  link_t   lk_rd_q;
  logic    lk_re, lk_we;
  logic [2:0]    lk_wm;
  logic [NW-1:0] lk_ra, lk_wa;
  link_t   lk_wd;

  // owner memory: valid bit and owning node per leaf slot
  logic [NW:0]   own_mem [SLOTS];
  logic [NW:0]   ow_rd_q;
  logic          ow_re, ow_we;
  logic [SW-1:0] ow_ra, ow_wa;
  logic [NW:0]   ow_wd;

  logic          div_start;
  logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;
  logic          div_done;

  logic [LW-1:0] qlv_c, nlv_c, want_c;
  logic [SW-1:0] own_slot_c;

  bba_div #(.DW(DW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      if (lk_wm[2]) link_mem[lk_wa].free <= lk_wd.free;
      if (lk_wm[1]) link_mem[lk_wa].nxt  <= lk_wd.nxt;
      if (lk_wm[0]) link_mem[lk_wa].prv  <= lk_wd.prv;
    end
    if (lk_re) begin
      lk_rd_q <= link_mem[lk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ow_we) begin
      own_mem[ow_wa] <= ow_wd;
    end
    if (ow_re) begin
      ow_rd_q <= own_mem[ow_ra];
    end
  end

  always_comb begin
    qlv_c = '0;
    nlv_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (div_quo[i]) qlv_c = LW'(i);
      if (node_q[i]) nlv_c = LW'(i);
    end
    if ((div_quo >> tl_q) != '0) begin
      want_c = tl_q;
    end else begin
      want_c = qlv_c;
    end
  end

  assign own_slot_c = SW'((node_q - (NW'(1) << lv_q)) << (tl_q - lv_q));

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cmd_d    = cmd_q;
    child_d  = child_q;
    lv_d     = lv_q;
    want_d   = want_q;
    tl_d     = tl_q;
    leaf_d   = leaf_q;
    node_d   = node_q;
    unode_d  = unode_q;
    lnk_d    = lnk_q;
    xn_d     = xn_q;
    slot_d   = slot_q;
    clr_d    = clr_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    status_d = status_q;
    lk_re = 1'b0;
    lk_ra = unode_q;
    lk_we = 1'b0;
    lk_wm = '0;
    lk_wa = node_q;
    lk_wd = '0;
    ow_re = 1'b0;
    ow_ra = slot_q;
    ow_we = 1'b0;
    ow_wa = slot_q;
    ow_wd = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = command_i;
          if (command_i == bba_pkg::CMD_ALLOC) begin
            if (request_size_i == '0) begin
              status_d = bba_pkg::ST_ZERO_SIZE;
              done_d   = 1'b1;
            end else begin
              div_start    = 1'b1;
              div_dividend = DW'(leaf_q) << tl_q;
              div_divisor  = DW'(request_size_i);
              state_d      = S_DIV;
            end
          end else begin
            if (block_address_i < bba_pkg::AddrW'(bba_pkg::HeaderBytes)) begin
              status_d = bba_pkg::ST_BAD_FREE;
              done_d   = 1'b1;
            end else begin
              div_start    = 1'b1;
              div_dividend = DW'(block_address_i
                                 - bba_pkg::AddrW'(bba_pkg::HeaderBytes));
              div_divisor  = DW'(leaf_q);
              state_d      = S_DIV;
            end
          end
        end
      end
      S_CLEAR: begin
        lk_we = 1'b1;
        lk_wm = WmAll;
        lk_wa = clr_q;
        lk_wd.free = (clr_q == NW'(1));
        if (!clr_q[NW-1]) begin
          ow_we = 1'b1;
          ow_wa = clr_q[SW-1:0];
        end
        clr_d = clr_q + NW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          if (cmd_q == bba_pkg::CMD_ALLOC) begin
            if (div_quo == '0) begin
              status_d = bba_pkg::ST_NO_BLOCK;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              want_d  = want_c;
              lv_d    = want_c;
              state_d = S_SCAN;
            end
          end else begin
            if (div_rem != '0 || (div_quo >> tl_q) != '0) begin
              status_d = bba_pkg::ST_BAD_FREE;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              slot_d  = div_quo[SW-1:0];
              state_d = S_OWN_RD;
            end
          end
        end
      end
      S_SCAN: begin
        if (cnt_q[lv_q] != '0) begin
          unode_d = head_q[lv_q];
          ret_d   = R_ALLOC;
          state_d = S_UNL_RD;
        end else if (lv_q == '0) begin
          status_d = bba_pkg::ST_NO_BLOCK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          lv_d = lv_q - LW'(1);
        end
      end
      S_UNL_RD: begin
        lk_re   = 1'b1;
        lk_ra   = unode_q;
        state_d = S_UNL_P;
      end
      S_UNL_P: begin
        lnk_d = lk_rd_q.prv;
        xn_d  = lk_rd_q.nxt;
        if (lk_rd_q.prv != '0) begin
          lk_we     = 1'b1;
          lk_wm     = WmNext;
          lk_wa     = lk_rd_q.prv;
          lk_wd.nxt = lk_rd_q.nxt;
        end else begin
          head_d[lv_q] = lk_rd_q.nxt;
        end
        state_d = S_UNL_X;
      end
      S_UNL_X: begin
        if (xn_q != '0) begin
          lk_we     = 1'b1;
          lk_wm     = WmPrev;
          lk_wa     = xn_q;
          lk_wd.prv = lnk_q;
        end else begin
          tail_d[lv_q] = lnk_q;
        end
        cnt_d[lv_q] = cnt_q[lv_q] - NW'(1);
        state_d     = S_UNL_N;
      end
      S_UNL_N: begin
        lk_we = 1'b1;
        lk_wm = WmAll;
        lk_wa = unode_q;
        case (ret_q)
          R_ALLOC: begin
            if (lv_q != want_q) begin
              lv_d    = lv_q + LW'(1);
              node_d  = {unode_q[NW-2:0], 1'b0};
              child_d = 1'b0;
              state_d = S_PB_N;
            end else begin
              node_d  = unode_q;
              state_d = S_OWN_WR;
            end
          end
          R_MERGE_N: begin
            unode_d = node_q ^ NW'(1);
            ret_d   = R_MERGE_B;
            state_d = S_UNL_RD;
          end
          R_MERGE_B: begin
            node_d  = node_q >> 1;
            lv_d    = lv_q - LW'(1);
            state_d = S_PF_N;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PB_N: begin
        lk_we      = 1'b1;
        lk_wm      = WmAll;
        lk_wa      = node_q;
        lk_wd.free = 1'b1;
        lk_wd.prv  = tail_q[lv_q];
        lnk_d      = tail_q[lv_q];
        if (tail_q[lv_q] == '0) head_d[lv_q] = node_q;
        tail_d[lv_q] = node_q;
        cnt_d[lv_q]  = cnt_q[lv_q] + NW'(1);
        state_d      = S_PB_T;
      end
      S_PB_T: begin
        if (lnk_q != '0) begin
          lk_we     = 1'b1;
          lk_wm     = WmNext;
          lk_wa     = lnk_q;
          lk_wd.nxt = node_q;
        end
        if (!child_q) begin
          node_d  = node_q | NW'(1);
          child_d = 1'b1;
          state_d = S_PB_N;
        end else begin
          unode_d = head_q[lv_q];
          ret_d   = R_ALLOC;
          state_d = S_UNL_RD;
        end
      end
      S_OWN_WR: begin
        ow_we    = 1'b1;
        ow_wa    = own_slot_c;
        ow_wd    = {1'b1, node_q};
        status_d = bba_pkg::ST_OK;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_OWN_RD: begin
        ow_re   = 1'b1;
        ow_ra   = slot_q;
        state_d = S_OWN_CHK;
      end
      S_OWN_CHK: begin
        if (!ow_rd_q[NW] || ow_rd_q[NW-1:0] == '0) begin
          status_d = bba_pkg::ST_BAD_FREE;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          node_d  = ow_rd_q[NW-1:0];
          lk_re   = 1'b1;
          lk_ra   = ow_rd_q[NW-1:0];
          state_d = S_FLG_CHK;
        end
      end
      S_FLG_CHK: begin
        if (lk_rd_q.free) begin
          status_d = bba_pkg::ST_BAD_FREE;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ow_we   = 1'b1;
          ow_wa   = slot_q;
          lv_d    = nlv_c;
          state_d = S_PF_N;
        end
      end
      S_PF_N: begin
        lk_we      = 1'b1;
        lk_wm      = WmAll;
        lk_wa      = node_q;
        lk_wd.free = 1'b1;
        lk_wd.nxt  = head_q[lv_q];
        lnk_d      = head_q[lv_q];
        if (head_q[lv_q] == '0) tail_d[lv_q] = node_q;
        head_d[lv_q] = node_q;
        cnt_d[lv_q]  = cnt_q[lv_q] + NW'(1);
        state_d      = S_PF_H;
      end
      S_PF_H: begin
        if (lnk_q != '0) begin
          lk_we     = 1'b1;
          lk_wm     = WmPrev;
          lk_wa     = lnk_q;
          lk_wd.prv = node_q;
        end
        if (node_q == NW'(1) || lv_q == '0) begin
          status_d = bba_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_BUD_RD;
        end
      end
      S_BUD_RD: begin
        lk_re   = 1'b1;
        lk_ra   = node_q ^ NW'(1);
        state_d = S_BUD_CHK;
      end
      S_BUD_CHK: begin
        if (!lk_rd_q.free) begin
          status_d = bba_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          unode_d = node_q;
          ret_d   = R_MERGE_N;
          state_d = S_UNL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // config write re-initializes the pool
    if (cfg_we_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_d[i] = '0;
        tail_d[i] = '0;
        cnt_d[i]  = '0;
      end
      head_d[0] = NW'(1);
      tail_d[0] = NW'(1);
      cnt_d[0]  = NW'(1);
      if (cfg_idx_i == bba_pkg::CFG_TREE_LEVELS) begin
        if (int'(cfg_wdata_i[bba_pkg::TlCfgW-1:0]) > NUM_LEVELS - 1) begin
          tl_d = LW'(NUM_LEVELS - 1);
        end else begin
          tl_d = LW'(cfg_wdata_i[bba_pkg::TlCfgW-1:0]);
        end
      end else begin
        if (cfg_wdata_i < bba_pkg::CfgW'(bba_pkg::HeaderBytes)) begin
          leaf_d = bba_pkg::LeafW'(bba_pkg::HeaderBytes);
        end else if (cfg_wdata_i > bba_pkg::CfgW'(bba_pkg::LeafMax)) begin
          leaf_d = bba_pkg::LeafW'(bba_pkg::LeafMax);
        end else begin
          leaf_d = cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      tl_q     <= LW'(TlReset);
      leaf_q   <= bba_pkg::LeafW'(64);
      done_q   <= 1'b0;
      status_q <= '0;
      ret_q    <= R_ALLOC;
      cmd_q    <= 1'b0;
      child_q  <= 1'b0;
      lv_q     <= '0;
      want_q   <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      head_q[0] <= NW'(1);
      tail_q[0] <= NW'(1);
      cnt_q[0]  <= NW'(1);
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      tl_q     <= tl_d;
      leaf_q   <= leaf_d;
      done_q   <= done_d;
      status_q <= status_d;
      ret_q    <= ret_d;
      cmd_q    <= cmd_d;
      child_q  <= child_d;
      lv_q     <= lv_d;
      want_q   <= want_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    unode_q <= unode_d;
    lnk_q   <= lnk_d;
    xn_q    <= xn_d;
    slot_q  <= slot_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe while engine still working");

  a_start_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cfg_we_i) |=> (busy_o || done_o))
    else $error("accepted transfer produced neither work nor result");

  a_root_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= NW'(1))
    else $error("root level list holds more than one block");

  a_bad_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == bba_pkg::ST_BAD_FREE) |-> cmd_q == bba_pkg::CMD_FREE)
    else $error("invalid free status on an allocate");

  a_merge_lvl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUD_RD) |-> lv_q != '0)
    else $error("buddy check at root level");

endmodule
